// ===== hdl/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// Seniority shaker sorter package
// Record widths, the stored entry layout and the compare unit interface types.
// ----------------------------------------------------------------------------
package sss_pkg;

   localparam int KEY_W = 7;
   localparam int TAG_W = 8;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef enum logic [1:0] {
      DIR_FWD = 2'b01,
      DIR_BWD = 2'b10
   } dir_type;

   typedef struct packed {
      entry_type wr_entry;
      entry_type carry;
      logic      swap;
   } cmp_result_type;

endpackage

// ===== hdl/sss_if.sv =====
// ----------------------------------------------------------------------------
// Seniority shaker sorter channels
// Valid/ready channels for the incoming records and the sorted results.
// ----------------------------------------------------------------------------
interface sss_req_if;
   logic                      valid;
   logic                      ready;
   logic                      is_director;
   logic [sss_pkg::KEY_W-1:0] years_as_director;
   logic [sss_pkg::KEY_W-1:0] years_in_service;
   logic [sss_pkg::TAG_W-1:0] record_tag;
   logic                      last_record;

   modport source (output valid, is_director, years_as_director, years_in_service,
                   record_tag, last_record, input ready);
   modport sink (input valid, is_director, years_as_director, years_in_service,
                 record_tag, last_record, output ready);
endinterface

interface sss_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [sss_pkg::TAG_W-1:0] out_tag;
   logic [sss_pkg::KEY_W-1:0] seniority;
   logic                      last_out;

   modport source (output valid, out_tag, seniority, last_out, input ready);
   modport sink (input valid, out_tag, seniority, last_out, output ready);
endinterface

// ===== hdl/seniority_shaker_sorter.sv =====
// ----------------------------------------------------------------------------
// Seniority shaker sorter
// Collects records, sorts them stably by seniority and streams them out.
// ----------------------------------------------------------------------------
// Records enter on the req channel, one per cycle while ready is high. The key
// is years_as_director for directors and years_in_service otherwise. Records
// beyond MAX_RECORDS are dropped. The record marked last_record starts the
// sort, and ready stays low until the last sorted result has been loaded
// into the output register.
// The sort walks one compare-swap per cycle through the single shared compare
// unit and the record memory, and each half pass also passes through its prime,
// load and end states. Emission reads each result from the registered memory in
// S_EMIT_READ and puts it into the output register in S_EMIT_PUT, which waits
// while the output register holds a result the receiver has not taken; a stalled
// result simply waits in the output register. The rsp channel marks the final
// result with last_out. Loading resumes as soon as the final result is
// registered.
// Reset empties the record set and drops any result not yet taken; the
// memory itself is not cleared.
// ----------------------------------------------------------------------------
module seniority_shaker_sorter #(
   parameter int MAX_RECORDS = 64
) (
   input  logic      clock,
   input  logic      reset,
   sss_req_if.sink   req,
   sss_rsp_if.source rsp
);

   localparam int IDX_W = $clog2(MAX_RECORDS);
   localparam int CNT_W = $clog2(MAX_RECORDS + 1);

   typedef enum logic [10:0] {
      S_LOAD      = 11'b000_0000_0001,
      S_FWD_PRIME = 11'b000_0000_0010,
      S_FWD_LOAD  = 11'b000_0000_0100,
      S_FWD_STEP  = 11'b000_0000_1000,
      S_FWD_END   = 11'b000_0001_0000,
      S_BWD_PRIME = 11'b000_0010_0000,
      S_BWD_LOAD  = 11'b000_0100_0000,
      S_BWD_STEP  = 11'b000_1000_0000,
      S_BWD_END   = 11'b001_0000_0000,
      S_EMIT_READ = 11'b010_0000_0000,
      S_EMIT_PUT  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] left_ff, left_in;
   logic [IDX_W-1:0] right_ff, right_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             swapped_ff, swapped_in;
   sss_pkg::entry_type carry_ff, carry_in;
   sss_pkg::entry_type rd_data_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [sss_pkg::TAG_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic [sss_pkg::KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic                      rsp_last_ff, rsp_last_in;

   sss_pkg::entry_type store_ff [MAX_RECORDS];

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   sss_pkg::entry_type wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;

   logic                   req_fire;
   logic                   rsp_free;
   logic                   rsp_load;
   logic                   emit_last;
   logic                   has_room;
   logic [CNT_W-1:0]       count_after;
   sss_pkg::dir_type       cmp_dir;
   sss_pkg::cmp_result_type cmp_result;

   sss_cmp_unit u_cmp (
      .dir     (cmp_dir),
      .carry   (carry_ff),
      .fetched (rd_data_ff),
      .result  (cmp_result)
   );

   assign req.ready   = (state_ff == S_LOAD);
   assign req_fire    = req.valid && req.ready;
   assign has_room    = count_ff < CNT_W'(MAX_RECORDS);
   assign count_after = has_room ? count_ff + CNT_W'(1) : count_ff;
   assign rsp_free    = !rsp_valid_ff || rsp.ready;
   assign emit_last   = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign cmp_dir     = (state_ff == S_FWD_STEP) ? sss_pkg::DIR_FWD : sss_pkg::DIR_BWD;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      idx_in      = idx_ff;
      swapped_in  = swapped_ff;
      carry_in    = carry_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = cmp_result.wr_entry;
      rd_en       = 1'b0;
      rd_addr     = idx_ff;
      rsp_load    = 1'b0;
      rsp_tag_in  = rsp_tag_ff;
      rsp_key_in  = rsp_key_ff;
      rsp_last_in = rsp_last_ff;

      unique case (state_ff)
         S_LOAD: begin
            wr_addr     = count_ff[IDX_W-1:0];
            wr_data.key = req.is_director ? req.years_as_director : req.years_in_service;
            wr_data.tag = req.record_tag;
            if (req_fire) begin
               wr_en    = has_room;
               count_in = count_after;
               if (req.last_record) begin
                  idx_in = '0;
                  if (count_after < CNT_W'(2)) begin
                     state_in = S_EMIT_READ;
                  end else begin
                     left_in  = '0;
                     right_in = IDX_W'(count_after - CNT_W'(1));
                     state_in = S_FWD_PRIME;
                  end
               end
            end
         end
         S_FWD_PRIME: begin
            rd_en      = 1'b1;
            rd_addr    = left_ff;
            idx_in     = left_ff;
            swapped_in = 1'b0;
            state_in   = S_FWD_LOAD;
         end
         S_FWD_LOAD: begin
            carry_in = rd_data_ff;
            rd_en    = 1'b1;
            rd_addr  = idx_ff + IDX_W'(1);
            state_in = S_FWD_STEP;
         end
         S_FWD_STEP: begin
            wr_en    = 1'b1;
            carry_in = cmp_result.carry;
            if (cmp_result.swap) begin
               swapped_in = 1'b1;
            end
            if (idx_ff + IDX_W'(1) == right_ff) begin
               state_in = S_FWD_END;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + IDX_W'(2);
               idx_in  = idx_ff + IDX_W'(1);
            end
         end
         S_FWD_END: begin
            wr_en    = 1'b1;
            wr_addr  = right_ff;
            wr_data  = carry_ff;
            right_in = right_ff - IDX_W'(1);
            if (right_ff - IDX_W'(1) > left_ff) begin
               state_in = S_BWD_PRIME;
            end else begin
               idx_in   = '0;
               state_in = S_EMIT_READ;
            end
         end
         S_BWD_PRIME: begin
            rd_en    = 1'b1;
            rd_addr  = right_ff;
            idx_in   = right_ff;
            state_in = S_BWD_LOAD;
         end
         S_BWD_LOAD: begin
            carry_in = rd_data_ff;
            rd_en    = 1'b1;
            rd_addr  = idx_ff - IDX_W'(1);
            state_in = S_BWD_STEP;
         end
         S_BWD_STEP: begin
            wr_en    = 1'b1;
            carry_in = cmp_result.carry;
            if (cmp_result.swap) begin
               swapped_in = 1'b1;
            end
            if (idx_ff - IDX_W'(1) == left_ff) begin
               state_in = S_BWD_END;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff - IDX_W'(2);
               idx_in  = idx_ff - IDX_W'(1);
            end
         end
         S_BWD_END: begin
            wr_en   = 1'b1;
            wr_addr = left_ff;
            wr_data = carry_ff;
            left_in = left_ff + IDX_W'(1);
            if (swapped_ff && (left_ff + IDX_W'(1) < right_ff)) begin
               state_in = S_FWD_PRIME;
            end else begin
               idx_in   = '0;
               state_in = S_EMIT_READ;
            end
         end
         S_EMIT_READ: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = S_EMIT_PUT;
         end
         S_EMIT_PUT: begin
            if (rsp_free) begin
               rsp_load    = 1'b1;
               rsp_tag_in  = rd_data_ff.tag;
               rsp_key_in  = rd_data_ff.key;
               rsp_last_in = emit_last;
               if (emit_last) begin
                  count_in   = '0;
                  left_in    = '0;
                  right_in   = '0;
                  swapped_in = 1'b0;
                  state_in   = S_LOAD;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_EMIT_READ;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         swapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         swapped_ff   <= swapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      carry_ff    <= carry_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_tag   = rsp_tag_ff;
   assign rsp.seniority = rsp_key_ff;
   assign rsp.last_out  = rsp_last_ff;

   a_fwd_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FWD_STEP) |-> (idx_ff < right_ff))
      else $error("Forward step index reached the right bound.");

   a_bwd_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BWD_STEP) |-> (idx_ff > left_ff))
      else $error("Backward step index reached the left bound.");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECORDS))
      else $error("Record count exceeds capacity.");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_PUT && rsp_load && emit_last)
      |=> (state_ff == S_LOAD && count_ff == '0 && rsp_valid_ff && rsp_last_ff))
      else $error("Final result did not return the block to loading.");

endmodule

// ===== hdl/sss_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// Seniority shaker sorter compare unit
// Strict compare of the carried entry against the fetched neighbor, giving the
// entry to write back and the entry that travels on.
// ----------------------------------------------------------------------------
module sss_cmp_unit (
   input  sss_pkg::dir_type        dir,
   input  sss_pkg::entry_type      carry,
   input  sss_pkg::entry_type      fetched,
   output sss_pkg::cmp_result_type result
);

   logic swap;

   always_comb begin
      unique case (dir)
         sss_pkg::DIR_FWD: swap = carry.key > fetched.key;
         sss_pkg::DIR_BWD: swap = carry.key < fetched.key;
         default:          swap = 1'b0;
      endcase
   end

   always_comb begin
      result.swap     = swap;
      result.wr_entry = swap ? fetched : carry;
      result.carry    = swap ? carry : fetched;
   end

endmodule

// ===== tb/sv/seniority_shaker_sorter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seniority shaker sorter testbench
// Sends record sets through the sorter and checks every sorted result against
// a stable sort that the testbench computes itself. Directed sets cover single
// records, key extremes, ties and reversed order. Random sets follow, with
// occasional sets that overrun the record capacity. The sender idles in
// bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module seniority_shaker_sorter_test;

   localparam int CAPACITY = 64;
   localparam int RANDOM_ITEMS = 320;

   typedef struct {
      logic [sss_pkg::TAG_W-1:0] tag;
      logic [sss_pkg::KEY_W-1:0] seniority;
      logic                      final_flag;
   } ranked_record_type;

   class sorted_ledger_type;
      sss_pkg::entry_type held [CAPACITY];
      int                 held_count;
      ranked_record_type  due [$];
      int                 errors;
      int                 checked;
      int                 overflow_sets;

      function void note_record(logic dir, logic [sss_pkg::KEY_W-1:0] lead_years,
                                logic [sss_pkg::KEY_W-1:0] service_years,
                                logic [sss_pkg::TAG_W-1:0] tag, logic fin,
                                int arrivals);
         sss_pkg::entry_type cur;
         ranked_record_type  r;
         int                 j;
         if (held_count < CAPACITY) begin
            held[held_count].key = dir ? lead_years : service_years;
            held[held_count].tag = tag;
            held_count++;
         end
         if (!fin)
            return;
         if (arrivals > CAPACITY)
            overflow_sets++;
         for (int i = 1; i < held_count; i++) begin
            cur = held[i];
            j = i - 1;
            while (j >= 0 && held[j].key > cur.key) begin
               held[j + 1] = held[j];
               j--;
            end
            held[j + 1] = cur;
         end
         for (int i = 0; i < held_count; i++) begin
            r.tag = held[i].tag;
            r.seniority = held[i].key;
            r.final_flag = (i == held_count - 1);
            due.push_back(r);
         end
         held_count = 0;
      endfunction

      function void check_result(logic [sss_pkg::TAG_W-1:0] tag,
                                 logic [sss_pkg::KEY_W-1:0] seniority,
                                 logic final_flag);
         ranked_record_type e;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: expected no result, got tag %0d seniority %0d last %0b",
                     $time, tag, seniority, final_flag);
            return;
         end
         e = due.pop_front();
         checked++;
         if (tag !== e.tag || seniority !== e.seniority || final_flag !== e.final_flag) begin
            errors++;
            $display("%0t: mismatch expected tag %0d seniority %0d last %0b,",
                     $time, e.tag, e.seniority, e.final_flag);
            $display("%0t:          actual tag %0d seniority %0d last %0b",
                     $time, tag, seniority, final_flag);
         end
      endfunction

      function int pending();
         return due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   sss_req_if req_ch ();
   sss_rsp_if rsp_ch ();

   seniority_shaker_sorter dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   sorted_ledger_type ledger = new();

   int        burst_left;
   bit        gaps_on;
   int        set_arrivals;
   int        records_sent;
   int        sets_sent;
   logic [7:0]  stall_mask = 8'hFF;
   logic [15:0] stall_tick = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         ledger.check_result(rsp_ch.out_tag, rsp_ch.seniority, rsp_ch.last_out);
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick[5:0] == 6'd0) begin
         if ($urandom_range(0, 3) == 0)
            stall_mask <= 8'hFF;
         else
            stall_mask <= 8'($urandom) | (8'd1 << $urandom_range(0, 7));
      end
      rsp_ch.ready <= stall_mask[stall_tick[2:0]];
   end

   task automatic push_record(input logic dir, input logic [sss_pkg::KEY_W-1:0] lead_years,
                              input logic [sss_pkg::KEY_W-1:0] service_years,
                              input logic [sss_pkg::TAG_W-1:0] tag, input logic fin);
      int gap;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 6);
         if (gaps_on) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_ch.valid <= 1'b1;
      req_ch.is_director <= dir;
      req_ch.years_as_director <= lead_years;
      req_ch.years_in_service <= service_years;
      req_ch.record_tag <= tag;
      req_ch.last_record <= fin;
      do
         @(posedge clock);
      while (!req_ch.ready);
      set_arrivals++;
      records_sent++;
      ledger.note_record(dir, lead_years, service_years, tag, fin, set_arrivals);
      if (fin) begin
         set_arrivals = 0;
         sets_sent++;
      end
      burst_left--;
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (ledger.pending() != 0)
         @(posedge clock);
   endtask

   task automatic random_set(input int size, input int span);
      for (int i = 0; i < size; i++)
         push_record(1'($urandom_range(0, 1)), 7'($urandom_range(0, span)),
                     7'($urandom_range(0, span)), 8'($urandom_range(0, 255)),
                     i == size - 1);
   endtask

   initial begin
      int size;
      int span;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.is_director = 1'b0;
      req_ch.years_as_director = '0;
      req_ch.years_in_service = '0;
      req_ch.record_tag = '0;
      req_ch.last_record = 1'b0;
      rsp_ch.ready = 1'b0;
      burst_left = 0;
      gaps_on = 1'b1;
      set_arrivals = 0;
      records_sent = 0;
      sets_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A single record, with the widest key and tag values.
      push_record(1'b1, 7'd127, 7'd0, 8'd255, 1'b1);

      // Mixed directors and staff, extreme keys and ties that must keep order.
      push_record(1'b0, 7'd127, 7'd0, 8'd0, 1'b0);
      push_record(1'b1, 7'd0, 7'd127, 8'd1, 1'b0);
      push_record(1'b0, 7'd0, 7'd127, 8'd2, 1'b0);
      push_record(1'b1, 7'd127, 7'd127, 8'd3, 1'b0);
      push_record(1'b0, 7'd0, 7'd5, 8'd4, 1'b0);
      push_record(1'b1, 7'd5, 7'd0, 8'd5, 1'b0);
      push_record(1'b0, 7'd127, 7'd5, 8'd6, 1'b0);
      push_record(1'b1, 7'd64, 7'd1, 8'd128, 1'b0);
      push_record(1'b0, 7'd85, 7'd0, 8'd254, 1'b1);

      // Strictly descending keys, the longest shaker run for its size.
      for (int i = 0; i < 6; i++)
         push_record(1'b0, 7'd42, 7'(60 - 10 * i), 8'(170 + i), i == 5);

      // All keys equal, so the output must match the arrival order.
      for (int i = 0; i < 4; i++)
         push_record(i[0], 7'd42, 7'd42, 8'(85 + i), i == 3);

      wait_for_drain();

      // Overrun the capacity first, then fill it exactly.
      random_set(CAPACITY + 2, 127);
      random_set(CAPACITY, 127);

      while (records_sent < RANDOM_ITEMS) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         span = ($urandom_range(0, 2) == 0) ? 3 : 127;
         if ($urandom_range(0, 9) == 0)
            size = $urandom_range(CAPACITY - 4, CAPACITY + 6);
         else
            size = $urandom_range(1, 12);
         random_set(size, span);
         if ($urandom_range(0, 5) == 0)
            wait_for_drain();
      end
      req_ch.valid <= 1'b0;

      wait_for_drain();
      repeat (40) @(posedge clock);

      $display("Sent %0d records in %0d sets, %0d of them over capacity.",
               records_sent, sets_sent, ledger.overflow_sets);
      $display("Checked %0d sorted results with %0d errors.", ledger.checked, ledger.errors);
      if (ledger.errors == 0 && ledger.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #20000000;
      $display("Timed out with %0d results outstanding.", ledger.pending());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
